// ===== sv/eosw_pkg.sv =====
// Shared types, constants and table-building functions for the even/odd sine waveshaper.
// Used by eosw_sine_interp and even_odd_sine_waveshaper; depends on nothing.
`default_nettype none

package eosw_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PAD_W      = 20;
    localparam int GAIN_W     = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_PAD = 2'd0,
        REG_EVEN_GAIN = 2'd1,
        REG_ODD_GAIN  = 2'd2
    } cfg_reg_t;

    // datapath widths that do not depend on the sample width
    localparam int U_W    = 30;   // u, signed Q.24
    localparam int SQ_W   = 60;   // u * u, Q.48
    localparam int USQ_W  = 33;   // u^2 rounded to Q.24, unsigned
    localparam int OP_W   = 55;   // u * odd_gain, Q.40
    localparam int OP6_W  = 58;
    localparam int EP_W   = 57;   // u^2 * even_gain, Q.40, unsigned
    localparam int EP6_W  = 60;
    localparam int PH_W   = 32;   // phase, one turn = 2^32
    localparam int SIN_W  = 32;   // sine, Q1.30
    localparam int FRAC_W = 16;   // interpolation fraction

    // latency of the sine lookup and interpolation unit
    localparam int SINE_LAT = 4;

    // clip limit for both indices, 12.0 in Q.40
    localparam longint CLIP_Q40 = 64'sd13194139533312;

    // angle constants, Q30
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    // sin(theta) for theta in [0, pi/2], Q30 in and out (nested Taylor form)
    function automatic longint unsigned quarter_sine(input longint unsigned theta);
        longint unsigned a2;
        longint unsigned t;
        longint unsigned term;
        longint unsigned r;
        a2   = (theta * theta) >> 30;
        t    = Q30_ONE;
        term = ((a2 * t) >> 30) / 64'd156;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((a2 * t) >> 30) / 64'd110;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((a2 * t) >> 30) / 64'd72;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((a2 * t) >> 30) / 64'd42;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((a2 * t) >> 30) / 64'd20;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((a2 * t) >> 30) / 64'd6;
        t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        r    = (theta * t) >> 30;
        if (r > Q30_ONE)
        begin
            r = Q30_ONE;
        end
        return r;
    endfunction

    // full-period table entry for angle theta in [0, 2*pi), Q30
    function automatic logic signed [SIN_W-1:0] sine_entry(input longint theta_in);
        longint          th;
        logic            neg;
        longint unsigned v;
        th  = theta_in;
        neg = 1'b0;
        if (th > PI_Q30)
        begin
            th  = th - PI_Q30;
            neg = 1'b1;
        end
        if (th > HALF_PI_Q30)
        begin
            th = PI_Q30 - th;
        end
        if (th < 0)
        begin
            th = 0;
        end
        v = quarter_sine(longint'(th));
        return neg ? SIN_W'(-longint'(v)) : SIN_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== sv/eosw_sine_interp.sv =====
// Sine lookup with linear interpolation: phase in, registered Q1.30 sine out; every stage advances only on en.
// Holds the full-period sine ROM; uses eosw_pkg for widths and table functions.
`default_nettype none

module eosw_sine_interp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [eosw_pkg::PH_W-1:0]       phase,
    output logic signed [eosw_pkg::SIN_W-1:0]    sine
);

    localparam int AW     = $clog2(DEPTH);
    localparam int POS_W  = eosw_pkg::PH_W + AW;
    localparam int SIN_W  = eosw_pkg::SIN_W;
    localparam int FRAC_W = eosw_pkg::FRAC_W;
    localparam int DIF_W  = SIN_W + 1;
    localparam int PRD_W  = DIF_W + FRAC_W + 1;
    localparam int ACC_W  = PRD_W - FRAC_W;

    // constant table, one entry per generate branch
    logic signed [SIN_W-1:0] rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        localparam longint Theta =
            (eosw_pkg::TWO_PI_Q30 * longint'(g) + longint'(DEPTH / 2)) / longint'(DEPTH);
        assign rom[g] = eosw_pkg::sine_entry(Theta);
    end

    logic [POS_W-1:0]        pos;
    logic [AW-1:0]           k_next;
    logic [AW-1:0]           k1_next;
    logic [AW-1:0]           k_reg;
    logic [AW-1:0]           k1_reg;
    logic [FRAC_W-1:0]       fa_reg;
    logic [FRAC_W-1:0]       fb_reg;
    logic signed [SIN_W-1:0] y0_reg;
    logic signed [SIN_W-1:0] y1_reg;
    logic signed [SIN_W-1:0] y0c_reg;
    logic signed [DIF_W-1:0] dif;
    logic signed [PRD_W-1:0] prd_next;
    logic signed [PRD_W-1:0] prd_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [SIN_W-1:0] sine_reg;

    // table position: integer part selects the entry, next 16 bits are the fraction
    assign pos     = {{AW{1'b0}}, phase} * POS_W'(DEPTH);
    assign k_next  = pos[POS_W-1:eosw_pkg::PH_W];
    assign k1_next = (k_next == AW'(DEPTH - 1)) ? '0 : k_next + AW'(1);

    assign dif      = {y1_reg[SIN_W-1], y1_reg} - {y0_reg[SIN_W-1], y0_reg};
    assign prd_next = $signed({{(PRD_W-DIF_W){dif[DIF_W-1]}}, dif})
                    * $signed({{(PRD_W-FRAC_W){1'b0}}, fb_reg});
    // arithmetic shift floors
    assign acc = {{(ACC_W-SIN_W){y0c_reg[SIN_W-1]}}, y0c_reg} + prd_reg[PRD_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg    <= k_next;
            k1_reg   <= k1_next;
            fa_reg   <= pos[eosw_pkg::PH_W-1:eosw_pkg::PH_W-FRAC_W];
            y0_reg   <= rom[k_reg];
            y1_reg   <= rom[k1_reg];
            fb_reg   <= fa_reg;
            prd_reg  <= prd_next;
            y0c_reg  <= y0_reg;
            sine_reg <= acc[SIN_W-1:0];
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

// ===== sv/even_odd_sine_waveshaper.sv =====
// Even/odd two-term sine waveshaper, top level: config registers, pipeline, output skid.
// Uses eosw_pkg and two eosw_sine_interp instances.
//
// Use:
//   Samples enter on in_valid/in_ready/sample_in (signed Q1.(SAMPLE_WIDTH-1)) and shaped
//   samples leave on out_valid/out_ready/sample_out, saturated to the same format.
//   A transfer happens on a rising edge with valid and ready both high.
//   Gains are written through cfg_we/cfg_index/cfg_data while the block is idle:
//   index 0 input pad (Q4.16), 1 even gain (Q8.16), 2 odd gain (Q8.16); other
//   indices are ignored and bits above a register's width are dropped.
//   Throughput: one sample per cycle while in_ready is high. The datapath has 11
//   stages (pad multiply, u^2 and gain multiplies, clip, table position, ROM read,
//   interpolation, mix and round) ahead of the output register.
//   Stalls: the whole pipeline advances together. A finished result waiting on
//   out_ready sits in the output register while the pipeline keeps going; one more
//   result is caught in a skid register, and only then does in_ready drop.
//   in_ready comes straight from a register, so there is no combinational path
//   from out_ready.
//   Reset: asynchronous, active low; empties the pipeline and output, and loads
//   unity gains into all three registers. No clearing pass is needed.
`default_nettype none

module even_odd_sine_waveshaper #(
    parameter int SAMPLE_WIDTH     = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [eosw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [eosw_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]           sample_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PAD_W  = eosw_pkg::PAD_W;
    localparam int GAIN_W = eosw_pkg::GAIN_W;
    localparam int U_W    = eosw_pkg::U_W;
    localparam int SQ_W   = eosw_pkg::SQ_W;
    localparam int USQ_W  = eosw_pkg::USQ_W;
    localparam int OP_W   = eosw_pkg::OP_W;
    localparam int OP6_W  = eosw_pkg::OP6_W;
    localparam int EP_W   = eosw_pkg::EP_W;
    localparam int EP6_W  = eosw_pkg::EP6_W;
    localparam int PH_W   = eosw_pkg::PH_W;
    localparam int SIN_W  = eosw_pkg::SIN_W;
    localparam int P1_W   = SW + PAD_W + 1;    // sample * pad
    localparam int USH    = SW - 9;            // Q.(SW+15) down to Q.24
    localparam int Y_W    = SIN_W + 1;
    localparam int NST    = 7 + eosw_pkg::SINE_LAT;

    localparam logic signed [P1_W-1:0]  U_RND  = P1_W'(1) <<< (USH - 1);
    localparam logic [SQ_W-1:0]         SQ_RND = SQ_W'(1) << 23;
    localparam logic signed [OP6_W-1:0] CLIP_O = OP6_W'(eosw_pkg::CLIP_Q40);
    localparam logic [EP6_W-1:0]        CLIP_E = EP6_W'(eosw_pkg::CLIP_Q40);
    localparam logic signed [Y_W-1:0]   SMAX   = (Y_W'(1) <<< (SW - 1)) - Y_W'(1);
    localparam logic signed [Y_W-1:0]   SMIN   = -SMAX - Y_W'(1);

    // ---------------------------------------------------------------- config
    logic [PAD_W-1:0]  pad_reg;
    logic [GAIN_W-1:0] even_gain_reg;
    logic [GAIN_W-1:0] odd_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= PAD_W'(65536);
            even_gain_reg <= GAIN_W'(65536);
            odd_gain_reg  <= GAIN_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eosw_pkg::REG_INPUT_PAD: pad_reg       <= cfg_data[PAD_W-1:0];
                eosw_pkg::REG_EVEN_GAIN: even_gain_reg <= cfg_data[GAIN_W-1:0];
                eosw_pkg::REG_ODD_GAIN:  odd_gain_reg  <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    // en advances every stage at once; it drops only while the skid is occupied
    logic           en;
    logic [NST-1:0] v_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;

    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // ---------------------------------------------------------------- datapath
    // stage 1: sample * pad
    logic signed [P1_W-1:0] p1_next;
    logic signed [P1_W-1:0] p1_reg;
    // stage 2: u, rounded half up to Q.24
    logic signed [P1_W-1:0] u_sum;
    logic signed [U_W-1:0]  u2_reg;
    // stage 3: u^2, u delayed
    logic signed [SQ_W-1:0] sq_next;
    logic [SQ_W-1:0]        sq3_reg;
    logic signed [U_W-1:0]  u3_reg;
    // stage 4: u^2 to Q.24; u * odd gain
    logic [SQ_W-1:0]        usq_sum;
    logic [USQ_W-1:0]       usq4_reg;
    logic signed [OP_W-1:0] op_next;
    logic signed [OP_W-1:0] op4_reg;
    // stage 5: u^2 * even gain; odd index x6, clip, phase
    logic [EP_W-1:0]         ep_next;
    logic [EP_W-1:0]         ep5_reg;
    logic signed [OP6_W-1:0] opx;
    logic signed [OP6_W-1:0] op6;
    logic signed [OP6_W-1:0] io_clip;
    logic [PH_W-1:0]         pho5_reg;
    // stage 6: even index x6, clip, phase
    logic [EP6_W-1:0]        epx;
    logic [EP6_W-1:0]        ep6;
    logic [EP6_W-1:0]        ie_clip;
    logic [PH_W-1:0]         phe6_reg;
    logic [PH_W-1:0]         pho6_reg;
    // stages 7-10: table lookup and interpolation
    logic signed [SIN_W-1:0] sin_e;
    logic signed [SIN_W-1:0] sin_o;
    // stage 11: mean, rounding, saturation
    logic signed [Y_W-1:0]   mix;
    logic signed [SIN_W-1:0] r;
    logic signed [Y_W-1:0]   y_wide;
    logic signed [SW-1:0]    res_next;
    logic signed [SW-1:0]    res_reg;

    assign p1_next = $signed({{(PAD_W+1){sample_in[SW-1]}}, sample_in})
                   * $signed({{(SW+1){1'b0}}, pad_reg});

    // u fits in 30 bits, the top of the shifted sum
    assign u_sum = p1_reg + U_RND;

    assign sq_next = $signed({{(SQ_W-U_W){u2_reg[U_W-1]}}, u2_reg})
                   * $signed({{(SQ_W-U_W){u2_reg[U_W-1]}}, u2_reg});

    assign usq_sum = sq3_reg + SQ_RND;
    assign op_next = $signed({{(OP_W-U_W){u3_reg[U_W-1]}}, u3_reg})
                   * $signed({{(OP_W-GAIN_W){1'b0}}, odd_gain_reg});

    assign ep_next = {{(EP_W-USQ_W){1'b0}}, usq4_reg} * {{(EP_W-GAIN_W){1'b0}}, even_gain_reg};
    assign opx     = {{(OP6_W-OP_W){op4_reg[OP_W-1]}}, op4_reg};
    assign op6     = (opx <<< 2) + (opx <<< 1);

    always_comb
    begin
        if (op6 > CLIP_O)
        begin
            io_clip = CLIP_O;
        end
        else if (op6 < -CLIP_O)
        begin
            io_clip = -CLIP_O;
        end
        else
        begin
            io_clip = op6;
        end
    end

    assign epx     = {{(EP6_W-EP_W){1'b0}}, ep5_reg};
    assign ep6     = (epx << 2) + (epx << 1);
    assign ie_clip = (ep6 > CLIP_E) ? CLIP_E : ep6;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            u2_reg   <= u_sum[P1_W-1:USH];
            sq3_reg  <= sq_next;
            u3_reg   <= u2_reg;
            usq4_reg <= usq_sum[USQ_W+23:24];
            op4_reg  <= op_next;
            ep5_reg  <= ep_next;
            pho5_reg <= io_clip[PH_W+7:8];
            phe6_reg <= ie_clip[PH_W+7:8];
            pho6_reg <= pho5_reg;
            res_reg  <= res_next;
        end
    end

    eosw_sine_interp #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_even (
        .clk   (clk),
        .en    (en),
        .phase (phe6_reg),
        .sine  (sin_e)
    );

    eosw_sine_interp #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_odd (
        .clk   (clk),
        .en    (en),
        .phase (pho6_reg),
        .sine  (sin_o)
    );

    // mean of the two sines, floored to Q1.30
    assign mix = {sin_e[SIN_W-1], sin_e} + {sin_o[SIN_W-1], sin_o};
    assign r   = mix[Y_W-1:1];

    if (SAMPLE_WIDTH <= 31)
    begin : g_narrow
        localparam int SH = 31 - SAMPLE_WIDTH;
        if (SH > 0)
        begin : g_round
            localparam logic signed [Y_W-1:0] Y_RND = Y_W'(1) <<< (SH - 1);
            assign y_wide = ($signed({r[SIN_W-1], r}) + Y_RND) >>> SH;
        end
        else
        begin : g_exact
            assign y_wide = {r[SIN_W-1], r};
        end
    end
    else
    begin : g_wide
        assign y_wide = {r, 1'b0};
    end

    // a full-scale +1.0 lands one above the largest sample and saturates
    always_comb
    begin
        if (y_wide > SMAX)
        begin
            res_next = SMAX[SW-1:0];
        end
        else if (y_wide < SMIN)
        begin
            res_next = SMIN[SW-1:0];
        end
        else
        begin
            res_next = y_wide[SW-1:0];
        end
    end

    // ---------------------------------------------------------------- output + skid
    logic signed [SW-1:0] out_data_reg;
    logic signed [SW-1:0] skid_data_reg;
    logic                 out_free;
    logic                 last_move;

    assign out_free  = ~out_valid_reg | out_ready;
    assign last_move = en & v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_move;
            end
        end
        else if (last_move)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (last_move)
            begin
                out_data_reg <= res_reg;
            end
        end
        else if (last_move)
        begin
            skid_data_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // ---------------------------------------------------------------- assertions
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid result not moved to the output after a transfer");

    a_blocked_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NST-1] && en && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("finished result lost while the output was stalled");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== dv/even_odd_sine_waveshaper_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for even_odd_sine_waveshaper: bursty sample transfers, random
// output back-pressure, register phases and a bit-exact shaping predictor.
// Depends on eosw_pkg and the even_odd_sine_waveshaper RTL; reads no files.

module even_odd_sine_waveshaper_tb;

    localparam int SW          = 24;
    localparam int DEPTH       = 1024;
    localparam int LATENCY     = 11;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 150;

    localparam int IDX_W  = eosw_pkg::CFG_IDX_W;
    localparam int DW     = eosw_pkg::CFG_DATA_W;
    localparam int PAD_W  = eosw_pkg::PAD_W;
    localparam int GAIN_W = eosw_pkg::GAIN_W;

    // index that decodes to no register; writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // Q30 angles and the index clip limit (12.0 in Q.40)
    localparam longint ANG_ONE     = 64'sd1073741824;
    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint ANG_TWO_PI  = 64'sd6746518852;
    localparam longint IDX_LIMIT   = 64'sd12 << 40;

    localparam longint SMP_MAX = 64'sd8388607;
    localparam longint SMP_MIN = -64'sd8388608;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_FREE,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in eight
        RX_CHOKE    // ready about one cycle in ten, at random
    } rx_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [IDX_W-1:0]            cfg_index;
    logic [DW-1:0]               cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [SW-1:0]        sample_in;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SW-1:0]        sample_out;

    // predictor copy of the registers
    logic [PAD_W-1:0]            pad_val;
    logic [GAIN_W-1:0]           even_val;
    logic [GAIN_W-1:0]           odd_val;

    // full-period sine table, Q1.30
    logic signed [31:0]          sine_rom [DEPTH];

    logic signed [SW-1:0]        stim_q [$];    // samples waiting for their input transfer
    logic signed [SW-1:0]        shaped_q [$];  // predicted outputs, oldest first

    logic                        sent = 1'b0;   // current item went across at the last edge
    int                          burst_left = 0;
    int                          gap_left = 0;
    rx_mode_t                    rx_mode = RX_FREE;
    int                          rx_left = 0;
    int                          rx_tick = 0;
    int                          n_in = 0;
    int                          n_out = 0;
    int                          n_err = 0;

    even_odd_sine_waveshaper #(
        .SAMPLE_WIDTH     (SW),
        .SINE_TABLE_DEPTH (DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sine at an index held in Q.40: the fractional turn picks the table entry and a
    // 16-bit fraction; interpolation floors, and the entry after the last wraps to 0.
    function automatic longint turn_sine(input longint idx40);
        longint          idx32;
        longint unsigned pos;
        int              k;
        int              k1;
        longint          frac;
        longint          y0;
        longint          y1;
        idx32 = idx40 >>> 8;
        pos   = ($unsigned(idx32) & 64'hFFFF_FFFF) * DEPTH;
        k     = int'(pos >> 32);
        k1    = (k == DEPTH - 1) ? 0 : k + 1;
        frac  = longint'((pos >> 16) & 64'hFFFF);
        y0    = sine_rom[k];
        y1    = sine_rom[k1];
        return y0 + (((y1 - y0) * frac) >>> 16);
    endfunction

    // Expected shaped sample for one input under the current register copy.
    function automatic logic signed [SW-1:0] shape_sample(input logic signed [SW-1:0] s);
        longint u;
        longint usq;
        longint ie;
        longint io;
        longint mix;
        longint y;
        // pad: Q1.23 * Q4.16 -> Q.24, round half up
        u   = (longint'(s) * longint'(pad_val) + 64'sd16384) >>> 15;
        usq = (u * u + (64'sd1 << 23)) >>> 24;
        // both indices end in Q.40; the even one can never go negative
        ie  = usq * longint'(even_val) * 6;
        io  = u * longint'(odd_val) * 6;
        if (ie > IDX_LIMIT)
            ie = IDX_LIMIT;
        if (io > IDX_LIMIT)
            io = IDX_LIMIT;
        else if (io < -IDX_LIMIT)
            io = -IDX_LIMIT;
        mix = (turn_sine(ie) + turn_sine(io)) >>> 1;
        // Q1.30 -> Q1.23, round half up, then saturate (a full +1 lands here)
        y   = (mix + 64'sd64) >>> 7;
        if (y > SMP_MAX)
            y = SMP_MAX;
        if (y < SMP_MIN)
            y = SMP_MIN;
        return y[SW-1:0];
    endfunction

    // Register write on the plain port; the predictor copy follows the RTL's
    // decode (bits above a register's width dropped, unknown index ignored).
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            eosw_pkg::REG_INPUT_PAD: pad_val = val[PAD_W-1:0];
            eosw_pkg::REG_EVEN_GAIN: even_val = val;
            eosw_pkg::REG_ODD_GAIN:  odd_val = val;
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    // Block until every sample has gone in and every prediction has been met, then
    // let the pipeline settle before anything else touches the registers.
    task automatic wait_idle;
        while (stim_q.size() > 0 || shaped_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Sender: walks the sample queue in bursts of random length with random gaps.
    // A presented sample stays put until the rising edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || sent))
        begin
            sent = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                in_valid  <= 1'b1;
                sample_in <= stim_q[0];
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 48);
                burst_left--;
                // a zero gap chains two bursts into one unbroken stretch
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between back-pressure patterns after runs of random length.
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: out_ready <= (rx_tick % 8 == 0);
            default:   out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Monitor: predicts on each input transfer, checks on each output transfer.
    always @(posedge clk)
    begin
        logic signed [SW-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                void'(stim_q.pop_front());
                shaped_q.push_back(shape_sample(sample_in));
                sent = 1'b1;
                n_in++;
            end
            if (out_valid && out_ready)
            begin
                n_out++;
                if (shaped_q.size() == 0)
                begin
                    if (n_err < 10)
                        $display("unexpected output transfer: sample_out %0d", sample_out);
                    n_err++;
                end
                else
                begin
                    want = shaped_q.pop_front();
                    if (sample_out !== want)
                    begin
                        if (n_err < 10)
                            $display("mismatch on output %0d: sample_out %0d, expected %0d",
                                     n_out, sample_out, want);
                        n_err++;
                    end
                end
            end
        end
    end

    initial
    begin
        longint          th;
        longint unsigned a2;
        longint unsigned tt;
        longint unsigned term;
        longint unsigned v;
        logic            neg;
        logic signed [SW-1:0] smp;
        int              mag;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = eosw_pkg::REG_INPUT_PAD;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample_in = '0;
        out_ready = 1'b0;
        pad_val   = 20'd65536;
        even_val  = 24'd65536;
        odd_val   = 24'd65536;

        // Sine table: angle of each entry rounded to Q30, folded into the first
        // quadrant, then a nested Taylor series whose divisors are (2m)(2m+1).
        for (int i = 0; i < DEPTH; i++)
        begin
            th  = (ANG_TWO_PI * i + DEPTH / 2) / DEPTH;
            neg = 1'b0;
            if (th > ANG_PI)
            begin
                th  = th - ANG_PI;
                neg = 1'b1;
            end
            if (th > ANG_HALF_PI)
                th = ANG_PI - th;
            if (th < 0)
                th = 0;
            a2 = ($unsigned(th) * $unsigned(th)) >> 30;
            tt = ANG_ONE;
            for (int m = 6; m >= 1; m--)
            begin
                term = ((a2 * tt) >> 30) / ((2 * m) * (2 * m + 1));
                tt   = (term >= ANG_ONE) ? 64'd0 : ANG_ONE - term;
            end
            v = ($unsigned(th) * tt) >> 30;
            if (v > ANG_ONE)
                v = ANG_ONE;
            sine_rom[i] = 32'(neg ? -longint'(v) : longint'(v));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, unity gains out of reset: zero, the smallest steps, both rails,
        // halves and thirds of full scale.
        stim_q.push_back(24'sd0);        stim_q.push_back(24'sd1);
        stim_q.push_back(-24'sd1);       stim_q.push_back(24'sd8388607);
        stim_q.push_back(-24'sd8388608); stim_q.push_back(24'sd4194304);
        stim_q.push_back(-24'sd4194304); stim_q.push_back(24'sd2796203);
        stim_q.push_back(-24'sd2796203); stim_q.push_back(24'sd65536);
        stim_q.push_back(-24'sd65536);   stim_q.push_back(24'sd5592405);
        stim_q.push_back(24'sd1398101);  stim_q.push_back(-24'sd7777777);
        stim_q.push_back(24'sd12345);
        wait_idle();

        // Write to the unused index must leave the gains alone; the pad write carries
        // junk above bit 19. Pad 1.0, even 1.5, odd 0.75 with u = 0.5 puts both
        // indices at a quarter turn exactly: full-scale sine, saturated output.
        write_reg(REG_SPARE, 24'h000000);
        write_reg(eosw_pkg::REG_INPUT_PAD, 24'hF10000);
        write_reg(eosw_pkg::REG_EVEN_GAIN, 24'd98304);
        write_reg(eosw_pkg::REG_ODD_GAIN, 24'd49152);
        stim_q.push_back(24'sd4194304);  stim_q.push_back(-24'sd4194304);
        stim_q.push_back(24'sd8388607);  stim_q.push_back(-24'sd8388608);
        stim_q.push_back(24'sd0);        stim_q.push_back(24'sd2097152);
        wait_idle();

        // Random phases, each under its own register setting; every phase drains
        // completely before the next set of writes.
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(eosw_pkg::REG_INPUT_PAD, 24'h0FFFFF);
                    write_reg(eosw_pkg::REG_EVEN_GAIN, 24'hFFFFFF);
                    write_reg(eosw_pkg::REG_ODD_GAIN, 24'hFFFFFF);
                end
                1:
                begin
                    write_reg(eosw_pkg::REG_INPUT_PAD, 24'h000000);
                    write_reg(eosw_pkg::REG_EVEN_GAIN, 24'h000000);
                    write_reg(eosw_pkg::REG_ODD_GAIN, 24'h000000);
                end
                2:
                begin
                    write_reg(eosw_pkg::REG_INPUT_PAD, DW'($urandom));
                    write_reg(eosw_pkg::REG_EVEN_GAIN, DW'($urandom_range(0, 262143)));
                    write_reg(eosw_pkg::REG_ODD_GAIN, DW'($urandom_range(0, 262143)));
                end
                3:
                begin
                    write_reg(eosw_pkg::REG_INPUT_PAD, 24'd65536);
                    write_reg(eosw_pkg::REG_EVEN_GAIN, 24'd65536);
                    write_reg(eosw_pkg::REG_ODD_GAIN, 24'd65536);
                    write_reg(REG_SPARE, DW'($urandom));
                end
                7:
                begin
                    write_reg(eosw_pkg::REG_INPUT_PAD, DW'($urandom));
                    write_reg(eosw_pkg::REG_EVEN_GAIN, DW'($urandom));
                    write_reg(eosw_pkg::REG_ODD_GAIN, DW'($urandom));
                end
                default:
                begin
                    // moderate settings keep the indices mostly inside the clip
                    write_reg(eosw_pkg::REG_INPUT_PAD, DW'($urandom_range(0, 262144)));
                    write_reg(eosw_pkg::REG_EVEN_GAIN, DW'($urandom_range(0, 1048576)));
                    write_reg(eosw_pkg::REG_ODD_GAIN, DW'($urandom_range(0, 1048576)));
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                        smp = SW'($urandom);
                    5, 6, 7:
                    begin
                        // quiet signals of random magnitude, either sign
                        mag = $urandom_range(4, 22);
                        smp = SW'($urandom_range(0, (1 << mag) - 1));
                        if ($urandom_range(0, 1) == 1)
                            smp = -smp;
                    end
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       smp = 24'sd8388607;
                            1:       smp = -24'sd8388608;
                            2:       smp = 24'sd0;
                            default: smp = -24'sd1;
                        endcase
                    end
                endcase
                stim_q.push_back(smp);
            end
            wait_idle();
        end

        $display("Ran %0d sample transfers through %0d register settings, checked %0d outputs,",
                 n_in, N_PHASES + 2, n_out);
        $display("with bursty input, four back-pressure patterns and %0d mismatches.", n_err);
        if (n_err == 0 && shaped_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
